// File: rtl/core/per_second_traffic_statistics_macros.svh
// Assertion helpers used by the RTL.
`ifndef PER_SECOND_TRAFFIC_STATISTICS_MACROS_SVH
`define PER_SECOND_TRAFFIC_STATISTICS_MACROS_SVH

// Property that must hold at every edge outside reset.
`define PSTAT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSTAT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pstat_pkg.sv
package pstat_pkg;

  localparam int unsigned RoleSetDepth = 256;
  localparam int unsigned AnySetDepth  = 512;
  localparam int unsigned WindowUs     = 1000000;
  localparam int unsigned UsPerSec     = 1000000;
  localparam int unsigned GapMax       = 999999;

  localparam int unsigned SecW   = 32;
  localparam int unsigned UsecW  = 20;
  localparam int unsigned TsW    = 52;
  localparam int unsigned LenW   = 16;
  localparam int unsigned IpW    = 32;
  localparam int unsigned WinW   = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned BytesW = 48;
  localparam int unsigned AvgW   = 24;
  localparam int unsigned GapW   = 20;
  localparam int unsigned DsW    = 9;
  localparam int unsigned DaW    = 10;

  // Shared divider: dividend covers bytes * 256, divisor a 32-bit count.
  localparam int unsigned DivW   = 56;
  localparam int unsigned DsrW   = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TIME,
    S_WIN,
    S_WINW,
    S_AVG,
    S_AVGW,
    S_GAP,
    S_GAPW,
    S_EMIT,
    S_ACC,
    S_SCAN,
    S_INS_A,
    S_INS_B
  } pstat_state_e;

endpackage

// File: rtl/core/pstat_div.sv
module pstat_div import pstat_pkg::*; #(
  parameter int unsigned DIV_W = DivW,
  parameter int unsigned DSR_W = DsrW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned CntBits = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]   quo_q;
  logic [DSR_W-1:0]   rem_q;
  logic [DSR_W-1:0]   dsr_q;
  logic [CntBits-1:0] cnt_q;
  logic               done_q;
  logic [DSR_W:0]     trial;
  logic [DSR_W:0]     diff;
  logic               ge;

  // One quotient bit per cycle, restoring.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntBits'(DIV_W);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CntBits'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/core/per_second_traffic_statistics.sv
// Packet: accept, timestamp, then the window number by reciprocal multiply, a table scan over
// max(src, dst, any fill) entries and the insert states S_INS_A and S_INS_B; the input stalls
// until the packet is done. A packet before the base time or the open window is dropped.
// Closing a window (on a later packet or a flush) runs the average and gap divisions (no gap
// division with no gap); the result is then loaded once the output register is free.
// Reset is asynchronous, active low: no window open, empty tables, no result held.
`include "per_second_traffic_statistics_macros.svh"

module per_second_traffic_statistics import pstat_pkg::*; #(
  parameter int unsigned ROLE_SET_DEPTH = RoleSetDepth,
  parameter int unsigned ANY_SET_DEPTH  = AnySetDepth,
  parameter int unsigned WINDOW_US      = WindowUs
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [SecW-1:0]   ts_sec_i,
  input  logic [UsecW-1:0]  ts_usec_i,
  input  logic [LenW-1:0]   pkt_len_i,
  input  logic [IpW-1:0]    src_ip_i,
  input  logic [IpW-1:0]    dst_ip_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WinW-1:0]   window_index_o,
  output logic [CntW-1:0]   pkt_count_o,
  output logic [BytesW-1:0] total_bytes_o,
  output logic [AvgW-1:0]   avg_len_q8_o,
  output logic [GapW-1:0]   avg_gap_us_o,
  output logic [DsW-1:0]    distinct_src_o,
  output logic [DsW-1:0]    distinct_dst_o,
  output logic [DaW-1:0]    distinct_any_o,
  output logic              set_overflow_o
);

  localparam int unsigned RoleFillW = $clog2(ROLE_SET_DEPTH + 1);
  localparam int unsigned AnyFillW  = $clog2(ANY_SET_DEPTH + 1);
  localparam int unsigned RoleAddrW = $clog2(ROLE_SET_DEPTH);
  localparam int unsigned AnyAddrW  = $clog2(ANY_SET_DEPTH);
  localparam int unsigned ScanW     = (RoleFillW > AnyFillW) ? RoleFillW : AnyFillW;

  localparam int unsigned HalfW = 32;
  localparam int unsigned RecW  = TsW + 1;
  localparam int unsigned AccW  = TsW + RecW;
  // floor(2^52 / WINDOW_US): the product quotient is low by at most one
  localparam logic [RecW-1:0]  Recip       = RecW'((64'd1 << TsW) / 64'(WINDOW_US));
  localparam logic [HalfW-1:0] WinDiv      = HalfW'(WINDOW_US);
  localparam logic [2:0]       WinStepLast = 3'd5;

  pstat_state_e state_q, state_d;

  // captured transaction
  logic              flush_q;
  logic [SecW-1:0]   sec_q;
  logic [UsecW-1:0]  usec_q;
  logic [LenW-1:0]   len_q;
  logic [IpW-1:0]    src_q;
  logic [IpW-1:0]    dst_q;
  logic [TsW-1:0]    t_q;
  logic [WinW-1:0]   w_q;

  // window state
  logic              started_q;
  logic [TsW-1:0]    base_q;
  logic [WinW-1:0]   cur_q;
  logic [CntW-1:0]   cnt_q;
  logic [BytesW-1:0] bytes_q;
  logic [TsW-1:0]    first_q;
  logic [TsW-1:0]    last_q;
  logic [RoleFillW-1:0] src_fill_q;
  logic [RoleFillW-1:0] dst_fill_q;
  logic [AnyFillW-1:0]  any_fill_q;
  logic              ovf_q;

  logic [AvgW-1:0]   avg_q;
  logic [GapW-1:0]   gap_q;

  // table scan
  logic [ScanW-1:0]  scan_q;
  logic [ScanW-1:0]  rd_idx_q;
  logic              rd_pend_q;
  logic              hit_src_q, hit_dst_q, hit_as_q, hit_ad_q;
  logic [ScanW-1:0]  scan_end;

  logic [IpW-1:0] src_mem [ROLE_SET_DEPTH];
  logic [IpW-1:0] dst_mem [ROLE_SET_DEPTH];
  logic [IpW-1:0] any_mem [ANY_SET_DEPTH];
  logic [IpW-1:0] src_rd_q, dst_rd_q, any_rd_q;

  // divider
  logic              div_start;
  logic [DivW-1:0]   div_dividend;
  logic [DsrW-1:0]   div_divisor;
  logic              div_done;
  logic [DivW-1:0]   div_quo;

  // window number by reciprocal multiply
  logic [TsW-1:0]     span_q;
  logic [2:0]         win_step_q;
  logic [AccW-1:0]    prod_acc_q;
  logic [HalfW-1:0]   win_rem_q;
  logic [HalfW-1:0]   mul_a, mul_b;
  logic [2*HalfW-1:0] mul_p;
  logic [RecW-1:0]    q_est, q_win;

  logic [TsW-1:0]    base_eff;
  logic [CntW-1:0]   n_eff;
  logic              gap_run;
  logic [WinW-1:0]   w_new;
  logic              out_free;
  logic              out_load;
  logic              out_valid_q;
  logic [BytesW:0]   bytes_sum;

  pstat_div #(
    .DIV_W(DivW),
    .DSR_W(DsrW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign base_eff  = started_q ? base_q : t_q;
  assign n_eff     = (cnt_q != '0) ? cnt_q : CntW'(1);
  assign gap_run   = (cnt_q > CntW'(1)) && (last_q > first_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign bytes_sum = {1'b0, bytes_q} + (BytesW + 1)'(len_q);

  // four partial products of span * Recip, then the remainder check
  always_comb begin
    mul_a = span_q[HalfW-1:0];
    mul_b = Recip[HalfW-1:0];
    unique case (win_step_q)
      3'd1: mul_b = HalfW'(Recip[RecW-1:HalfW]);
      3'd2: mul_a = HalfW'(span_q[TsW-1:HalfW]);
      3'd3: begin
        mul_a = HalfW'(span_q[TsW-1:HalfW]);
        mul_b = HalfW'(Recip[RecW-1:HalfW]);
      end
      3'd4: begin
        mul_a = q_est[HalfW-1:0];
        mul_b = WinDiv;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = (2 * HalfW)'(mul_a) * (2 * HalfW)'(mul_b);
  assign q_est = prod_acc_q[AccW-1:TsW];
  assign q_win = q_est + RecW'(win_rem_q >= WinDiv);

  // saturate the window number at all ones
  assign w_new = ((|q_win[RecW-1:WinW]) || (&q_win[WinW-1:0])) ? '1
               : q_win[WinW-1:0] + WinW'(1);

  always_comb begin
    scan_end = ScanW'(any_fill_q);
    if (ScanW'(src_fill_q) > scan_end) scan_end = ScanW'(src_fill_q);
    if (ScanW'(dst_fill_q) > scan_end) scan_end = ScanW'(dst_fill_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = n_eff;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!action_i) begin
            state_d = S_TIME;
          end else if (started_q) begin
            state_d = S_AVG;
          end
        end
      end
      S_TIME: state_d = S_WIN;
      S_WIN: begin
        // drop a packet that precedes the base time
        if (t_q < base_eff) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_WINW;
        end
      end
      S_WINW: begin
        if (win_step_q == WinStepLast) begin
          priority if (w_new == cur_q) begin
            state_d = S_ACC;
          end else if (w_new < cur_q) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_AVG;
          end
        end
      end
      S_AVG: begin
        div_start    = 1'b1;
        div_dividend = {bytes_q, 8'b0};
        div_divisor  = n_eff;
        state_d      = S_AVGW;
      end
      S_AVGW: if (div_done) state_d = S_GAP;
      S_GAP: begin
        div_dividend = DivW'(last_q - first_q);
        div_divisor  = cnt_q - CntW'(1);
        if (gap_run) begin
          div_start = 1'b1;
          state_d   = S_GAPW;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_GAPW: if (div_done) state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = flush_q ? S_IDLE : S_ACC;
        end
      end
      S_ACC: state_d = S_SCAN;
      S_SCAN: if (scan_q == scan_end && !rd_pend_q) state_d = S_INS_A;
      S_INS_A: state_d = S_INS_B;
      S_INS_B: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // captured transaction, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      flush_q <= action_i;
      sec_q   <= ts_sec_i;
      usec_q  <= ts_usec_i;
      len_q   <= pkt_len_i;
      src_q   <= src_ip_i;
      dst_q   <= dst_ip_i;
    end
    if (state_q == S_TIME) begin
      t_q <= TsW'(sec_q) * TsW'(UsPerSec) + TsW'(usec_q);
    end
    if (state_q == S_WIN) begin
      span_q     <= t_q - base_eff;
      win_step_q <= '0;
    end
    if (state_q == S_WINW) begin
      win_step_q <= win_step_q + 3'd1;
      unique case (win_step_q)
        3'd0: prod_acc_q <= AccW'(mul_p);
        3'd1, 3'd2: prod_acc_q <= prod_acc_q + (AccW'(mul_p) << HalfW);
        3'd3: prod_acc_q <= prod_acc_q + (AccW'(mul_p) << (2 * HalfW));
        3'd4: win_rem_q <= span_q[HalfW-1:0] - mul_p[HalfW-1:0];
        default: begin
        end
      endcase
    end
    if (state_q == S_WINW && win_step_q == WinStepLast) begin
      w_q <= w_new;
    end
    if (state_q == S_AVGW && div_done) begin
      avg_q <= (|div_quo[DivW-1:AvgW]) ? '1 : div_quo[AvgW-1:0];
    end
    if (state_q == S_GAP && !gap_run) begin
      gap_q <= '0;
    end
    if (state_q == S_GAPW && div_done) begin
      gap_q <= (div_quo > DivW'(GapMax)) ? GapW'(GapMax) : div_quo[GapW-1:0];
    end
  end

  // window state and table bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      base_q     <= '0;
      cur_q      <= WinW'(1);
      cnt_q      <= '0;
      bytes_q    <= '0;
      first_q    <= '0;
      last_q     <= '0;
      src_fill_q <= '0;
      dst_fill_q <= '0;
      any_fill_q <= '0;
      ovf_q      <= 1'b0;
      scan_q     <= '0;
      rd_idx_q   <= '0;
      rd_pend_q  <= 1'b0;
      hit_src_q  <= 1'b0;
      hit_dst_q  <= 1'b0;
      hit_as_q   <= 1'b0;
      hit_ad_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_WIN: begin
          // first packet fixes the base and opens window one
          if (!started_q) begin
            started_q  <= 1'b1;
            base_q     <= t_q;
            cur_q      <= WinW'(1);
            cnt_q      <= '0;
            bytes_q    <= '0;
            first_q    <= '0;
            last_q     <= '0;
            src_fill_q <= '0;
            dst_fill_q <= '0;
            any_fill_q <= '0;
            ovf_q      <= 1'b0;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            cnt_q      <= '0;
            bytes_q    <= '0;
            first_q    <= '0;
            last_q     <= '0;
            src_fill_q <= '0;
            dst_fill_q <= '0;
            any_fill_q <= '0;
            ovf_q      <= 1'b0;
            if (flush_q) begin
              started_q <= 1'b0;
              base_q    <= '0;
              cur_q     <= WinW'(1);
            end else begin
              cur_q <= w_q;
            end
          end
        end
        S_ACC: begin
          if (cnt_q == '0) first_q <= t_q;
          if (cnt_q != '1) cnt_q <= cnt_q + CntW'(1);
          bytes_q   <= bytes_sum[BytesW] ? '1 : bytes_sum[BytesW-1:0];
          last_q    <= t_q;
          scan_q    <= '0;
          rd_pend_q <= 1'b0;
          hit_src_q <= 1'b0;
          hit_dst_q <= 1'b0;
          hit_as_q  <= 1'b0;
          hit_ad_q  <= 1'b0;
        end
        S_SCAN: begin
          if (scan_q != scan_end) begin
            scan_q    <= scan_q + ScanW'(1);
            rd_idx_q  <= scan_q;
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (rd_pend_q) begin
            if (rd_idx_q < ScanW'(src_fill_q) && src_rd_q == src_q) hit_src_q <= 1'b1;
            if (rd_idx_q < ScanW'(dst_fill_q) && dst_rd_q == dst_q) hit_dst_q <= 1'b1;
            if (rd_idx_q < ScanW'(any_fill_q)) begin
              if (any_rd_q == src_q) hit_as_q <= 1'b1;
              if (any_rd_q == dst_q) hit_ad_q <= 1'b1;
            end
          end
        end
        S_INS_A: begin
          if (!hit_src_q) begin
            if (src_fill_q < RoleFillW'(ROLE_SET_DEPTH)) begin
              src_fill_q <= src_fill_q + RoleFillW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          if (!hit_dst_q) begin
            if (dst_fill_q < RoleFillW'(ROLE_SET_DEPTH)) begin
              dst_fill_q <= dst_fill_q + RoleFillW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
          if (!hit_as_q) begin
            if (any_fill_q < AnyFillW'(ANY_SET_DEPTH)) begin
              any_fill_q <= any_fill_q + AnyFillW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        S_INS_B: begin
          // a destination equal to the source was just handled as the source
          if (!hit_ad_q && dst_q != src_q) begin
            if (any_fill_q < AnyFillW'(ANY_SET_DEPTH)) begin
              any_fill_q <= any_fill_q + AnyFillW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // address tables: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    src_rd_q <= src_mem[scan_q[RoleAddrW-1:0]];
    dst_rd_q <= dst_mem[scan_q[RoleAddrW-1:0]];
    any_rd_q <= any_mem[scan_q[AnyAddrW-1:0]];
    if (state_q == S_INS_A) begin
      if (!hit_src_q && src_fill_q < RoleFillW'(ROLE_SET_DEPTH)) begin
        src_mem[src_fill_q[RoleAddrW-1:0]] <= src_q;
      end
      if (!hit_dst_q && dst_fill_q < RoleFillW'(ROLE_SET_DEPTH)) begin
        dst_mem[dst_fill_q[RoleAddrW-1:0]] <= dst_q;
      end
      if (!hit_as_q && any_fill_q < AnyFillW'(ANY_SET_DEPTH)) begin
        any_mem[any_fill_q[AnyAddrW-1:0]] <= src_q;
      end
    end
    if (state_q == S_INS_B && !hit_ad_q && dst_q != src_q &&
        any_fill_q < AnyFillW'(ANY_SET_DEPTH)) begin
      any_mem[any_fill_q[AnyAddrW-1:0]] <= dst_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      window_index_o <= cur_q;
      pkt_count_o    <= cnt_q;
      total_bytes_o  <= bytes_q;
      avg_len_q8_o   <= avg_q;
      avg_gap_us_o   <= gap_q;
      distinct_src_o <= DsW'(src_fill_q);
      distinct_dst_o <= DsW'(dst_fill_q);
      distinct_any_o <= DaW'(any_fill_q);
      set_overflow_o <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `PSTAT_ASSERT(a_fill_bounded,
    src_fill_q <= RoleFillW'(ROLE_SET_DEPTH) && dst_fill_q <= RoleFillW'(ROLE_SET_DEPTH)
    && any_fill_q <= AnyFillW'(ANY_SET_DEPTH), "address table fill beyond depth")
  `PSTAT_ASSERT(a_result_counted, !out_valid_o || pkt_count_o != '0,
    "result reported for an empty window")
  `PSTAT_ASSERT_NEXT(a_acc_counts, state_q == S_ACC, cnt_q != '0,
    "accumulated packet not counted")

endmodule
